/* rtl/bgtw_pkg.sv */
// bgtw_pkg: widths, register codes and pipeline record types for the bilinear tap core
package bgtw_pkg;

    // field and register widths
    localparam int POS_W      = 12;
    localparam int CFG_W      = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int IDX_W      = 12;
    localparam int WGT_W      = 17;
    localparam int FRAC_BITS  = 16;

    // internal widths
    localparam int COORD_W    = 6;    // clamped source coordinate, 0..63
    localparam int AXD_W      = 8;    // twice a target side, up to 254
    localparam int NUM_W      = 14;   // non-negative axis numerator
    localparam int AQ_W       = 7;    // axis quotient bits
    localparam int N_W        = 16;   // signed axis numerator before the sign split
    localparam int DEN_W      = 16;   // product of the two axis denominators
    localparam int PROD_W     = 16;   // weight numerator

    // iteration counts of the three dividers
    localparam int D1_STEPS   = POS_W;
    localparam int AX_STEPS   = AQ_W;
    localparam int W_STEPS    = WGT_W;

    // stages from input register to output register
    localparam int LAT = (D1_STEPS + 1) + 1 + (AX_STEPS + 1) + 1 + 1 + (W_STEPS + 1);

    localparam logic [CFG_W-1:0] MAX_SOURCE_SIDE = 7'd64;
    localparam logic [CFG_W-1:0] CFG_RESET       = 7'd16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SOURCE_SIZE = 2'd0,
        CFG_GRID_ROWS   = 2'd1,
        CFG_GRID_COLS   = 2'd2
    } cfg_addr_t;

    // position / cols divider state
    typedef struct packed {
        logic [POS_W-1:0] num;
        logic [CFG_W-1:0] rem;
        logic [POS_W-1:0] q;
    } div1_t;

    // one axis lane of the source-coordinate divider
    typedef struct packed {
        logic             neg;
        logic [AXD_W-1:0] negrem;
        logic [NUM_W-1:0] num;
        logic [AXD_W-1:0] rem;
        logic [AQ_W-1:0]  q;
    } axis_lane_t;

    // clamped neighbours and the two weight factors of one axis
    typedef struct packed {
        logic [COORD_W-1:0] c0;
        logic [COORD_W-1:0] c1;
        logic [AXD_W-1:0]   a;
        logic [AXD_W-1:0]   b;
    } coord_t;

    // one lane of the rounding weight divider
    typedef struct packed {
        logic [WGT_W-1:0] low;
        logic [DEN_W-1:0] rem;
        logic [WGT_W-1:0] q;
    } wlane_t;

    // the four tap indices riding alongside the weight divider
    typedef struct packed {
        logic [IDX_W-1:0] tl;
        logic [IDX_W-1:0] tr;
        logic [IDX_W-1:0] bl;
        logic [IDX_W-1:0] br;
    } tap_idx_t;

endpackage

/* rtl/bilinear_grid_tap_weights_core.sv */
// bilinear_grid_tap_weights_core: pipelined bilinear tap index and weight generator
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  ----------------------------------------
//  input     in         in_valid / in_stall    position
//  output    out        out_valid / out_stall  four tap indices, four Q16 weights, is_padding
//  config    in         cfg_write              cfg_index, cfg_data
//
//  one transfer per cycle in and out while the output is not stalled; the depth is set by the
//  bit-per-stage dividers (12 stages for row/column split, 7 for the axis
//  quotient, 17 for the rounded weights) plus the register stages between them
//  the whole pipeline advances together and freezes while the output transfer stalls
//  rst_n clears the valid bits and reloads the config registers and their clamped copies with 16
module bilinear_grid_tap_weights_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bgtw_pkg::POS_W-1:0]          position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bgtw_pkg::IDX_W-1:0]          top_left_index,
    output logic [bgtw_pkg::WGT_W-1:0]          top_left_weight,
    output logic [bgtw_pkg::IDX_W-1:0]          top_right_index,
    output logic [bgtw_pkg::WGT_W-1:0]          top_right_weight,
    output logic [bgtw_pkg::IDX_W-1:0]          bottom_left_index,
    output logic [bgtw_pkg::WGT_W-1:0]          bottom_left_weight,
    output logic [bgtw_pkg::IDX_W-1:0]          bottom_right_index,
    output logic [bgtw_pkg::WGT_W-1:0]          bottom_right_weight,
    output logic                                is_padding,
    input  logic                                cfg_write,
    input  logic [bgtw_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  logic [bgtw_pkg::CFG_W-1:0]          cfg_data
);

    localparam int D1  = bgtw_pkg::D1_STEPS;
    localparam int AS  = bgtw_pkg::AX_STEPS;
    localparam int WS  = bgtw_pkg::W_STEPS;
    localparam int LAT = bgtw_pkg::LAT;

    // configuration and derived values
    logic [bgtw_pkg::CFG_W-1:0]  src_size_reg, grid_rows_reg, grid_cols_reg;
    logic [bgtw_pkg::CFG_W-1:0]  s_eff_next, rows_eff_next, cols_eff_next;
    logic [bgtw_pkg::CFG_W-1:0]  s_eff_reg, rows_eff_reg, cols_eff_reg;
    logic [bgtw_pkg::AXD_W-1:0]  dy_reg, dx_reg, dy_next, dx_next;
    logic [bgtw_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [13:0]                 cells_next;

    // pipeline control
    logic            en;
    logic            pad0;
    logic [LAT-1:0]  vld_reg, vld_next, pad_reg, pad_next;

    // pipeline payload
    bgtw_pkg::div1_t      d1_reg    [D1+1];
    bgtw_pkg::div1_t      d1_next   [D1+1];
    logic [bgtw_pkg::N_W-1:0] n_reg [2];
    logic [bgtw_pkg::N_W-1:0] n_next [2];
    bgtw_pkg::axis_lane_t ax_reg    [AS+1][2];
    bgtw_pkg::axis_lane_t ax_next   [AS+1][2];
    bgtw_pkg::coord_t     coord_reg [2];
    bgtw_pkg::coord_t     coord_next [2];
    logic [bgtw_pkg::PROD_W-1:0] prod_reg [4];
    logic [bgtw_pkg::PROD_W-1:0] prod_next [4];
    bgtw_pkg::tap_idx_t   idx_reg, idx_next;
    bgtw_pkg::wlane_t     w_reg     [WS+1][4];
    bgtw_pkg::wlane_t     w_next    [WS+1][4];
    bgtw_pkg::tap_idx_t   tag_reg   [WS+1];
    bgtw_pkg::tap_idx_t   tag_next  [WS+1];

    logic [18:0] wsum;

    // clamp registers to their usable range
    always_comb
    begin
        if (src_size_reg == '0)
            s_eff_next = 7'd1;
        else if (src_size_reg > bgtw_pkg::MAX_SOURCE_SIDE)
            s_eff_next = bgtw_pkg::MAX_SOURCE_SIDE;
        else
            s_eff_next = src_size_reg;
        rows_eff_next = (grid_rows_reg == '0) ? 7'd1 : grid_rows_reg;
        cols_eff_next = (grid_cols_reg == '0) ? 7'd1 : grid_cols_reg;
        dy_next       = {rows_eff_next, 1'b0};
        dx_next       = {cols_eff_next, 1'b0};
        den_next      = 16'(dy_next) * 16'(dx_next);
        cells_next    = 14'(rows_eff_next) * 14'(cols_eff_next);
    end

    // config writes and derived values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_size_reg  <= bgtw_pkg::CFG_RESET;
            grid_rows_reg <= bgtw_pkg::CFG_RESET;
            grid_cols_reg <= bgtw_pkg::CFG_RESET;
            s_eff_reg     <= bgtw_pkg::CFG_RESET;
            rows_eff_reg  <= bgtw_pkg::CFG_RESET;
            cols_eff_reg  <= bgtw_pkg::CFG_RESET;
            dy_reg        <= 8'd32;
            dx_reg        <= 8'd32;
            den_reg       <= 16'd1024;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (bgtw_pkg::cfg_addr_t'(cfg_index))
                    bgtw_pkg::CFG_SOURCE_SIZE: src_size_reg  <= cfg_data;
                    bgtw_pkg::CFG_GRID_ROWS:   grid_rows_reg <= cfg_data;
                    bgtw_pkg::CFG_GRID_COLS:   grid_cols_reg <= cfg_data;
                    default: ;
                endcase
            end
            s_eff_reg    <= s_eff_next;
            rows_eff_reg <= rows_eff_next;
            cols_eff_reg <= cols_eff_next;
            dy_reg       <= dy_next;
            dx_reg       <= dx_next;
            den_reg      <= den_next;
        end
    end

    // whole pipeline moves unless the output transfer is held
    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    // next values of every stage
    always_comb
    begin
        bgtw_pkg::div1_t      d1_in;
        bgtw_pkg::axis_lane_t a_in;
        bgtw_pkg::wlane_t     w_in;
        logic [7:0]           t1;
        logic                 ge1;
        logic [8:0]           t2;
        logic                 ge2;
        logic [16:0]          t3;
        logic                 ge3;
        logic [bgtw_pkg::AXD_W-1:0]  dl [2];
        logic [bgtw_pkg::CFG_W-1:0]  kk [2];
        logic [bgtw_pkg::N_W-1:0]    pr;
        logic [bgtw_pkg::CFG_W-1:0]  sm1;
        logic [bgtw_pkg::CFG_W-1:0]  q1;
        logic [12:0]          row0, row1;
        logic [32:0]          nw;

        dl[0] = dy_reg;
        dl[1] = dx_reg;
        sm1   = s_eff_reg - 7'd1;

        // input stage: padding maps to position 0
        pad0        = {2'b00, position} >= cells_next;
        d1_next[0].num = pad0 ? '0 : position;
        d1_next[0].rem = '0;
        d1_next[0].q   = '0;

        // position / cols, one quotient bit a stage
        for (int k = 1; k <= D1; k++)
        begin
            d1_in = d1_reg[k-1];
            t1    = {d1_in.rem, d1_in.num[bgtw_pkg::POS_W-k]};
            ge1   = t1 >= {1'b0, cols_eff_reg};
            d1_next[k].num = d1_in.num;
            d1_next[k].rem = ge1 ? 7'(t1 - {1'b0, cols_eff_reg}) : t1[6:0];
            d1_next[k].q   = {d1_in.q[bgtw_pkg::POS_W-2:0], ge1};
        end

        // axis numerators (2k+1)*S - P
        kk[0] = d1_reg[D1].q[bgtw_pkg::CFG_W-1:0];
        kk[1] = d1_reg[D1].rem;
        for (int l = 0; l < 2; l++)
        begin
            pr        = 16'({kk[l], 1'b1}) * 16'(s_eff_reg);
            n_next[l] = pr - 16'(dl[l][7:1]);
        end

        // sign split: a negative numerator floors to -1
        for (int l = 0; l < 2; l++)
        begin
            ax_next[0][l].neg    = n_reg[l][bgtw_pkg::N_W-1];
            ax_next[0][l].num    = n_reg[l][bgtw_pkg::N_W-1] ? '0 : n_reg[l][13:0];
            ax_next[0][l].negrem = n_reg[l][7:0] + dl[l];
            ax_next[0][l].rem    = n_reg[l][bgtw_pkg::N_W-1] ? '0 : {1'b0, n_reg[l][13:7]};
            ax_next[0][l].q      = '0;
        end

        // axis quotient and remainder against 2P
        for (int k = 1; k <= AS; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                a_in = ax_reg[k-1][l];
                t2   = {a_in.rem, a_in.num[AS-k]};
                ge2  = t2 >= {1'b0, dl[l]};
                ax_next[k][l]     = a_in;
                ax_next[k][l].rem = ge2 ? 8'(t2 - {1'b0, dl[l]}) : t2[7:0];
                ax_next[k][l].q   = {a_in.q[bgtw_pkg::AQ_W-2:0], ge2};
            end
        end

        // clamp neighbours to the source edge, form weight factors
        for (int l = 0; l < 2; l++)
        begin
            a_in = ax_reg[AS][l];
            q1   = a_in.q + 7'd1;
            if (a_in.neg)
            begin
                coord_next[l].c0 = '0;
                coord_next[l].c1 = '0;
                coord_next[l].b  = a_in.negrem;
            end
            else
            begin
                coord_next[l].c0 = 6'((a_in.q > sm1) ? sm1 : a_in.q);
                coord_next[l].c1 = 6'((q1 > sm1) ? sm1 : q1);
                coord_next[l].b  = a_in.rem;
            end
            coord_next[l].a = dl[l] - coord_next[l].b;
        end

        // tap indices and weight numerators
        row0 = 13'(coord_reg[0].c0) * 13'(s_eff_reg);
        row1 = 13'(coord_reg[0].c1) * 13'(s_eff_reg);
        idx_next.tl = 12'(row0 + 13'(coord_reg[1].c0));
        idx_next.tr = 12'(row0 + 13'(coord_reg[1].c1));
        idx_next.bl = 12'(row1 + 13'(coord_reg[1].c0));
        idx_next.br = 12'(row1 + 13'(coord_reg[1].c1));
        prod_next[0] = 16'(coord_reg[0].a) * 16'(coord_reg[1].a);
        prod_next[1] = 16'(coord_reg[0].a) * 16'(coord_reg[1].b);
        prod_next[2] = 16'(coord_reg[0].b) * 16'(coord_reg[1].a);
        prod_next[3] = 16'(coord_reg[0].b) * 16'(coord_reg[1].b);

        // scaled numerator plus half the denominator for round to nearest
        for (int i = 0; i < 4; i++)
        begin
            nw = {1'b0, prod_reg[i], 16'b0} + 33'(den_reg[15:1]);
            w_next[0][i].rem = nw[32:17];
            w_next[0][i].low = nw[16:0];
            w_next[0][i].q   = '0;
        end
        tag_next[0] = idx_reg;

        // rounded weight quotients, one bit a stage
        for (int k = 1; k <= WS; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                w_in = w_reg[k-1][i];
                t3   = {w_in.rem, w_in.low[WS-k]};
                ge3  = t3 >= {1'b0, den_reg};
                w_next[k][i]     = w_in;
                w_next[k][i].rem = ge3 ? 16'(t3 - {1'b0, den_reg}) : t3[15:0];
                w_next[k][i].q   = {w_in.q[bgtw_pkg::WGT_W-2:0], ge3};
            end
            tag_next[k] = tag_reg[k-1];
        end

        // valid and padding flags travel with the data
        vld_next = {vld_reg[LAT-2:0], in_valid};
        pad_next = {pad_reg[LAT-2:0], pad0};
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pad_reg   <= pad_next;
            d1_reg    <= d1_next;
            n_reg     <= n_next;
            ax_reg    <= ax_next;
            coord_reg <= coord_next;
            prod_reg  <= prod_next;
            idx_reg   <= idx_next;
            w_reg     <= w_next;
            tag_reg   <= tag_next;
        end
    end

    // output register is the last weight stage
    assign out_valid           = vld_reg[LAT-1];
    assign is_padding          = pad_reg[LAT-1];
    assign top_left_index      = tag_reg[WS].tl;
    assign top_right_index     = tag_reg[WS].tr;
    assign bottom_left_index   = tag_reg[WS].bl;
    assign bottom_right_index  = tag_reg[WS].br;
    assign top_left_weight     = w_reg[WS][0].q;
    assign top_right_weight    = w_reg[WS][1].q;
    assign bottom_left_weight  = w_reg[WS][2].q;
    assign bottom_right_weight = w_reg[WS][3].q;

    assign wsum = 19'(top_left_weight) + 19'(top_right_weight)
                + 19'(bottom_left_weight) + 19'(bottom_right_weight);

    // input is held exactly when a finished result is held
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow the held output");

    // the four rounded weights add to one within rounding
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (wsum >= 19'd65534 && wsum <= 19'd65538))
        else $error("tap weights do not add to one");

    // the far neighbour never lies before the near one
    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (top_left_index <= bottom_right_index
                       && top_right_index <= bottom_right_index))
        else $error("tap indices out of order");

    // a frozen pipeline keeps its result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(top_left_weight)
                                      && $stable(bottom_right_index)))
        else $error("held result changed");

endmodule
